[src/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// sfd_pkg: shared types and constants for the single-precision divider
// Holds the front-to-back item type and the fixed result patterns.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int QBITS = 25;            // quotient bits developed per item
    localparam int QUEUE_DEPTH = 4;       // default depth of the decoupling queue

    localparam logic [31:0] ZDIV_NEG = 32'h4F80_0000;
    localparam logic [31:0] ZDIV_POS = 32'h4F00_0000;
    localparam logic [31:0] INF_POS  = 32'h7F80_0000;
    localparam logic [31:0] INF_NEG  = 32'hFF80_0000;
    localparam logic signed [10:0] EXP_BIAS_ADJ = 11'sd126;
    localparam logic signed [10:0] EXP_LIMIT    = 11'sd255;

    typedef enum logic [2:0] {
        CLS_ZDIV = 3'b001,
        CLS_ZERO = 3'b010,
        CLS_NORM = 3'b100
    } t_cls;

    // Classified item handed from the front to the back.
    typedef struct packed {
        t_cls               cls;
        logic               sign;
        logic signed [10:0] e;      // exponent after mantissa alignment
        logic [24:0]        num;    // aligned dividend mantissa
        logic [23:0]        den;    // divisor mantissa with hidden one
    } t_item;

endpackage

[src/single_float_divide.sv]
// ----------------------------------------------------------------------------
// single_float_divide: single-precision divider
// Divides two 32-bit float patterns; front classifier, queue, divide pipe.
// ----------------------------------------------------------------------------
// Input channel: i_valid with i_dividend and i_divisor; the block drives
// o_stall. An item is accepted at a rising edge with i_valid high and o_stall
// low. Output channel: o_valid with o_quotient and o_overflow; the receiver
// drives i_stall, and a result is taken at an edge with o_valid high and
// i_stall low.
// Throughput is one item per cycle while the receiver does not stall. The front
// register classifies each item (zero divisor, zero dividend, ordinary) and
// aligns the mantissas; a queue then feeds an entry register and 25 stages
// that each develop one quotient bit, and a final register rounds and packs
// the result.
// When the receiver stalls, the divide pipeline freezes and the queue fills;
// once it is full the stall reaches the input channel, and nothing is lost.
// Reset (synchronous, active low) empties the queue and clears every valid
// flag; no clearing pass is needed.
// ----------------------------------------------------------------------------
module single_float_divide #(
    parameter int QUEUE_DEPTH = sfd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_dividend,
    input  logic [31:0] i_divisor,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_quotient,
    output logic        o_overflow
);
    logic           w_f_valid;
    logic           w_f_stall;
    sfd_pkg::t_item w_f_item;
    logic           w_q_valid;
    logic           w_q_stall;
    sfd_pkg::t_item w_q_item;

    sfd_front u_front (
        .i_clk, .i_rst_n, .i_valid, .o_stall, .i_dividend, .i_divisor,
        .o_valid(w_f_valid), .i_stall(w_f_stall), .o_item(w_f_item)
    );

    sfd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
        .i_clk, .i_rst_n,
        .i_valid(w_f_valid), .o_stall(w_f_stall), .i_item(w_f_item),
        .o_valid(w_q_valid), .i_stall(w_q_stall), .o_item(w_q_item)
    );

    sfd_back u_back (
        .i_clk, .i_rst_n,
        .i_valid(w_q_valid), .o_stall(w_q_stall), .i_item(w_q_item),
        .o_valid, .i_stall, .o_quotient, .o_overflow
    );
endmodule

[src/sfd_front.sv]
// ----------------------------------------------------------------------------
// sfd_front: operand classification
// Registers each accepted item after deciding its class and aligning it.
// ----------------------------------------------------------------------------
module sfd_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  logic [31:0]    i_dividend,
    input  logic [31:0]    i_divisor,
    output logic           o_valid,
    input  logic           i_stall,
    output sfd_pkg::t_item o_item
);
    logic           r_valid;
    sfd_pkg::t_item r_item;
    sfd_pkg::t_item n_item;
    logic [23:0]    w_num;
    logic [23:0]    w_den;
    logic signed [10:0] w_ediff;

    assign o_stall = r_valid && i_stall;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_comb begin
        w_num   = {1'b1, i_dividend[22:0]};
        w_den   = {1'b1, i_divisor[22:0]};
        w_ediff = $signed({3'b000, i_dividend[30:23]}) - $signed({3'b000, i_divisor[30:23]})
                + sfd_pkg::EXP_BIAS_ADJ;
        n_item.sign = i_dividend[31] ^ i_divisor[31];
        n_item.den  = w_den;
        if (i_divisor[30:0] == 31'd0) begin
            n_item.cls = sfd_pkg::CLS_ZDIV;
        end else if (i_dividend[30:0] == 31'd0) begin
            n_item.cls = sfd_pkg::CLS_ZERO;
        end else begin
            n_item.cls = sfd_pkg::CLS_NORM;
        end
        if (w_num < w_den) begin
            n_item.num = {w_num, 1'b0};
            n_item.e   = w_ediff - 11'sd1;
        end else begin
            n_item.num = {1'b0, w_num};
            n_item.e   = w_ediff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_item <= n_item;
        end
    end
endmodule

[src/sfd_queue.sv]
// ----------------------------------------------------------------------------
// sfd_queue: decoupling queue
// Small FIFO between the classifier and the divide pipeline.
// ----------------------------------------------------------------------------
module sfd_queue #(
    parameter int DEPTH = sfd_pkg::QUEUE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  sfd_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_stall,
    output sfd_pkg::t_item o_item
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW:0] FULL = AW'(DEPTH) == '0 ? {1'b1, {AW{1'b0}}} : (AW+1)'(DEPTH);

    sfd_pkg::t_item r_mem [DEPTH];
    logic [AW-1:0]  r_wp;
    logic [AW-1:0]  r_rp;
    logic [AW:0]    r_cnt;
    logic           w_push;
    logic           w_pop;

    assign o_stall = (r_cnt == FULL);
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_mem[r_rp];
    assign w_push  = i_valid && !o_stall;
    assign w_pop   = o_valid && !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wp <= (r_wp == AW'(DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (w_pop) begin
                r_rp <= (r_rp == AW'(DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(w_push) - (AW+1)'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= FULL) else $error("queue count beyond depth");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == FULL && !w_pop) |=> r_cnt == FULL)
        else $error("queue count changed while full");
    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !w_pop) else $error("pop from empty queue");
endmodule

[src/sfd_back.sv]
// ----------------------------------------------------------------------------
// sfd_back: divide pipeline
// One restoring quotient bit per stage, then rounding and packing.
// ----------------------------------------------------------------------------
module sfd_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  sfd_pkg::t_item i_item,
    output logic           o_valid,
    input  logic           i_stall,
    output logic [31:0]    o_quotient,
    output logic           o_overflow
);
    localparam int NS = sfd_pkg::QBITS;

    // Stage k holds the partial remainder and quotient after k bits.
    logic                r_v   [NS+1];
    sfd_pkg::t_item      r_it  [NS+1];
    logic [24:0]         r_rem [NS+1];
    logic [NS-1:0]       r_q   [NS+1];
    logic                w_adv;
    logic                r_ov;
    logic [31:0]         r_quo;
    logic                r_ovf;
    logic [31:0]         n_quo;
    logic                n_ovf;

    // The whole pipe moves together; it halts only when the output is held.
    assign w_adv   = !(r_ov && i_stall);
    assign o_stall = !w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NS; k++) begin
                r_v[k] <= 1'b0;
            end
            r_ov <= 1'b0;
        end else if (w_adv) begin
            r_v[0] <= i_valid;
            for (int k = 1; k <= NS; k++) begin
                r_v[k] <= r_v[k-1];
            end
            r_ov <= r_v[NS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_it[0]  <= i_item;
            r_rem[0] <= i_item.num;
            r_q[0]   <= '0;
        end
    end

    for (genvar k = 1; k <= NS; k++) begin : g_stage
        logic [25:0] w_diff;
        assign w_diff = {1'b0, r_rem[k-1]} - {2'b00, r_it[k-1].den};
        always_ff @(posedge i_clk) begin
            if (w_adv) begin
                r_it[k] <= r_it[k-1];
                if (!w_diff[25]) begin
                    r_rem[k] <= {w_diff[23:0], 1'b0};
                    r_q[k]   <= {r_q[k-1][NS-2:0], 1'b1};
                end else begin
                    r_rem[k] <= {r_rem[k-1][23:0], 1'b0};
                    r_q[k]   <= {r_q[k-1][NS-2:0], 1'b0};
                end
            end
        end
    end

    always_comb begin
        logic signed [10:0] e;
        logic [4:0]         n;
        logic [26:0]        t;
        logic [26:0]        sh;
        logic [23:0]        qr;
        e     = r_it[NS].e;
        n     = 5'(-e);
        t     = '0;
        sh    = '0;
        qr    = '0;
        n_ovf = 1'b0;
        n_quo = '0;
        if (e >= 0) begin
            t  = 27'(r_q[NS]) + 27'd1;
            qr = t[24:1];
            e  = e + 11'sd1;
        end else begin
            if (e <= -11'sd25) begin
                qr = '0;
            end else begin
                t  = 27'(r_q[NS]) + (27'd1 << n);
                sh = t >> (n + 5'd1);
                qr = sh[23:0];
            end
            e = '0;
        end
        qr[23] = 1'b0;
        unique case (r_it[NS].cls)
            sfd_pkg::CLS_ZDIV: n_quo = r_it[NS].sign ? sfd_pkg::ZDIV_NEG : sfd_pkg::ZDIV_POS;
            sfd_pkg::CLS_ZERO: n_quo = {r_it[NS].sign, 31'd0};
            sfd_pkg::CLS_NORM: begin
                if (e >= sfd_pkg::EXP_LIMIT) begin
                    n_quo = r_it[NS].sign ? sfd_pkg::INF_NEG : sfd_pkg::INF_POS;
                    n_ovf = 1'b1;
                end else begin
                    n_quo = {r_it[NS].sign, e[7:0], qr[22:0]};
                end
            end
            default: n_quo = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_quo <= n_quo;
            r_ovf <= n_ovf;
        end
    end

    assign o_valid    = r_ov;
    assign o_quotient = r_quo;
    assign o_overflow = r_ovf;

    a_ovf_inf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ovf) |-> (r_quo[30:0] == sfd_pkg::INF_POS[30:0]))
        else $error("overflow without infinity");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && i_stall) |=> r_v[NS] == $past(r_v[NS]))
        else $error("pipe moved while output held");
    a_ovf_norm: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        n_ovf |-> r_it[NS].cls == sfd_pkg::CLS_NORM)
        else $error("overflow on special operand");
endmodule

[dv/testbench.sv]
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the single-precision divider
// Drives operand pairs through a directed table and then random traffic with
// random gaps and output stalls, predicts each quotient bit for bit and
// compares every result in order.
// ----------------------------------------------------------------------------
module testbench;

    localparam int N_RANDOM = 750;

    // One row of the directed table. When has_exp is set, the expected result
    // typed in the row is checked against the predictor as well.
    typedef struct {
        logic [31:0] dividend;
        logic [31:0] divisor;
        bit          has_exp;
        logic [31:0] quotient;
        logic        overflow;
    } t_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_dividend;
    logic [31:0] i_divisor;
    logic        o_valid;
    logic        i_stall;
    logic [31:0] o_quotient;
    logic        o_overflow;

    // Expected quotients and overflow flags, oldest first.
    logic [31:0] quot_fifo[$];
    logic        ovf_fifo[$];
    int          n_errors;

    single_float_divide dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_dividend (i_dividend),
        .i_divisor  (i_divisor),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_quotient (o_quotient),
        .o_overflow (o_overflow)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Bit-exact model of the divider: restoring division over 25 quotient
    // bits, round half up, denormal shift, hidden bit cleared, and the fixed
    // patterns for zero operands and exponent overflow.
    function automatic void divide_float(input logic [31:0] x, input logic [31:0] y,
                                         output logic [31:0] quot, output logic ovf);
        logic        sgn;
        int          e;
        logic [25:0] num;
        logic [25:0] den;
        logic [24:0] q;
        logic [63:0] t;
        int          n;
        sgn = x[31] ^ y[31];
        e = int'(x[30:23]) - int'(y[30:23]) + 126;
        ovf = 1'b0;
        if (y[30:0] == 31'd0) begin
            quot = sgn ? sfd_pkg::ZDIV_NEG : sfd_pkg::ZDIV_POS;
        end else if (x[30:0] == 31'd0) begin
            quot = {sgn, 31'd0};
        end else begin
            num = {3'b001, x[22:0]};
            den = {3'b001, y[22:0]};
            if (num < den) begin
                num = num << 1;
                e = e - 1;
            end
            q = '0;
            for (int b = 24; b >= 0; b--) begin
                if (num >= den) begin
                    q[b] = 1'b1;
                    num = num - den;
                end
                num = num << 1;
            end
            if (e >= 0) begin
                q = (q + 25'd1) >> 1;
                e = e + 1;
            end else begin
                n = -e;
                if (n >= 25) begin
                    q = '0;
                end else begin
                    t = 64'(q) + (64'd1 << n);
                    q = 25'(t >> (n + 1));
                end
                e = 0;
            end
            q[23] = 1'b0;
            if (e >= 255) begin
                quot = sgn ? sfd_pkg::INF_NEG : sfd_pkg::INF_POS;
                ovf = 1'b1;
            end else begin
                quot = {sgn, e[7:0], q[22:0]};
            end
        end
    endfunction

    // Half the time no gap at all, otherwise mostly a short one, now and then a long one.
    function automatic int gap_length();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(4, 30);
    endfunction

    // Random operand: a mix of raw patterns, zeros, and exponents near the
    // edges so that overflow and the denormal shift are both reached.
    function automatic logic [31:0] rand_operand();
        logic [31:0] v;
        int          r;
        v = $urandom();
        r = $urandom_range(0, 9);
        case (r)
            0: v[30:0] = '0;
            1: v[30:23] = 8'($urandom_range(0, 30));
            2: v[30:23] = 8'($urandom_range(225, 255));
            3: v[22:0] = $urandom_range(0, 1) ? '0 : 23'h7FFFFF;
            default: ;
        endcase
        return v;
    endfunction

    // Offer one item and hold it until the block accepts it. Valid stays
    // high on return so that a following item with no gap comes back to back.
    task automatic send_item(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] q;
        logic        f;
        int          gap;
        gap = gap_length();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid    <= 1'b1;
        i_dividend <= a;
        i_divisor  <= b;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        divide_float(a, b, q, f);
        quot_fifo.push_back(q);
        ovf_fifo.push_back(f);
        @(negedge i_clk);
    endtask

    // Result side: random stall, compare each accepted result in order.
    initial begin
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if ($urandom_range(0, 99) < 70) begin
                i_stall <= 1'b0;
            end else begin
                i_stall <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (quot_fifo.size() == 0) begin
                n_errors++;
                if (n_errors <= 10)
                    $display("unexpected result: quotient %h overflow %b",
                             o_quotient, o_overflow);
            end else begin
                if (o_quotient !== quot_fifo[0] || o_overflow !== ovf_fifo[0]) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch: expected %h/%b, got %h/%b",
                                 quot_fifo[0], ovf_fifo[0], o_quotient, o_overflow);
                end
                void'(quot_fifo.pop_front());
                void'(ovf_fifo.pop_front());
            end
        end
    end

    // Stimulus: directed table first, then random traffic.
    initial begin
        t_row        rows[$];
        logic [31:0] q;
        logic        f;
        int          wait_cycles;
        n_errors    = 0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_dividend  = '0;
        i_divisor   = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Zero divisor comes first and picks its pattern by sign alone.
        rows.push_back('{32'h3F80_0000, 32'h0000_0000, 1, sfd_pkg::ZDIV_POS, 0});
        rows.push_back('{32'h3F80_0000, 32'h8000_0000, 1, sfd_pkg::ZDIV_NEG, 0});
        rows.push_back('{32'h0000_0000, 32'h0000_0000, 1, sfd_pkg::ZDIV_POS, 0});
        rows.push_back('{32'h8000_0000, 32'h0000_0000, 1, sfd_pkg::ZDIV_NEG, 0});
        // Zero dividend gives a signed zero.
        rows.push_back('{32'h0000_0000, 32'h3F80_0000, 1, 32'h0000_0000, 0});
        rows.push_back('{32'h8000_0000, 32'h3F80_0000, 1, 32'h8000_0000, 0});
        rows.push_back('{32'h0000_0000, 32'hBF80_0000, 1, 32'h8000_0000, 0});
        // Ordinary values, exact and inexact.
        rows.push_back('{32'h3F80_0000, 32'h3F80_0000, 1, 32'h3F80_0000, 0});
        rows.push_back('{32'h4000_0000, 32'hBF80_0000, 1, 32'hC000_0000, 0});
        rows.push_back('{32'h3F80_0000, 32'h4040_0000, 0, '0, 0});
        rows.push_back('{32'h3FFF_FFFF, 32'h3F80_0001, 0, '0, 0});
        // Exponent overflow to signed infinity.
        rows.push_back('{32'h7F7F_FFFF, 32'h0080_0000, 1, sfd_pkg::INF_POS, 1});
        rows.push_back('{32'hFF7F_FFFF, 32'h0080_0000, 1, sfd_pkg::INF_NEG, 1});
        rows.push_back('{32'h7FFF_FFFF, 32'h0000_0001, 1, sfd_pkg::INF_POS, 1});
        // Denormal range, shift saturation and carry into the hidden bit.
        rows.push_back('{32'h0080_0000, 32'h4000_0000, 0, '0, 0});
        rows.push_back('{32'h0080_0000, 32'h7F7F_FFFF, 0, '0, 0});
        rows.push_back('{32'h0000_0001, 32'h7FFF_FFFF, 0, '0, 0});
        rows.push_back('{32'h00FF_FFFF, 32'h4000_0000, 0, '0, 0});
        rows.push_back('{32'h0FFF_FFFF, 32'h4F80_0000, 0, '0, 0});
        // Infinity and NaN patterns are plain numbers here.
        rows.push_back('{32'h7F80_0000, 32'h3F80_0000, 0, '0, 0});
        rows.push_back('{32'h7FC0_0000, 32'hFF80_0000, 0, '0, 0});
        rows.push_back('{32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, '0, 0});

        @(negedge i_clk);
        foreach (rows[i]) begin
            if (rows[i].has_exp) begin
                divide_float(rows[i].dividend, rows[i].divisor, q, f);
                if (q !== rows[i].quotient || f !== rows[i].overflow) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("table row %0d: expected %h/%b, predicted %h/%b",
                                 i, rows[i].quotient, rows[i].overflow, q, f);
                end
            end
            send_item(rows[i].dividend, rows[i].divisor);
        end

        for (int i = 0; i < N_RANDOM; i++) begin
            send_item(rand_operand(), rand_operand());
        end
        i_valid <= 1'b0;

        wait_cycles = 0;
        while (quot_fifo.size() != 0 && wait_cycles < 20000) begin
            @(posedge i_clk);
            wait_cycles++;
        end
        // Let any stray result surface before judging.
        repeat (40) @(posedge i_clk);
        if (n_errors == 0 && quot_fifo.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

    // Hard limit on run time.
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

[files.f]
src/sfd_pkg.sv
src/sfd_front.sv
src/sfd_queue.sv
src/sfd_back.sv
src/single_float_divide.sv
dv/testbench.sv
